>>> rtl/xxt_pkg.sv
`default_nettype none

package xxt_pkg;

  // Cipher constants.
  localparam logic [31:0] DELTA      = 32'h9e37_79b9;
  localparam int          NUM_CYCLES = 32;
  localparam int          NUM_HALF   = 2 * NUM_CYCLES;
  // Input whitening stage, one stage per half cycle, output whitening stage.
  localparam int          NUM_STAGES = NUM_HALF + 2;

  // Command codes.
  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_t;

  // Round function for two words: z and y are the same neighbor word.
  function automatic logic [31:0] mix(input logic [31:0] z, input logic [31:0] sum,
                                      input logic [31:0] key);
    logic [31:0] a;
    logic [31:0] b;
    a = ((z >> 5) ^ (z << 2)) + ((z >> 3) ^ (z << 4));
    b = (sum ^ z) + (key ^ z);
    return a ^ b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/xxt_if.sv
`default_nettype none

// Block channel into the cipher.
interface xxt_in_if;
  import xxt_pkg::*;
  logic        valid;
  logic        ready;
  cmd_t        command;
  logic [31:0] block_low;
  logic [31:0] block_high;

  modport source (output valid, output command, output block_low, output block_high,
                  input ready);
  modport sink (input valid, input command, input block_low, input block_high,
                output ready);
endinterface

// Result channel out of the cipher.
interface xxt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_low;
  logic [31:0] result_high;

  modport source (output valid, output result_low, output result_high, input ready);
  modport sink (input valid, input result_low, input result_high, output ready);
endinterface

`default_nettype wire

>>> rtl/xxtea_block_cipher_with_whitening_unit.sv
// Two-word XXTEA block cipher with key whitening.
// A transaction on blk_in carries a command (encrypt or decrypt) and one 64-bit
// block as two little-endian words; each one yields exactly one transaction on
// blk_out with the processed block, in the order the blocks were taken.
// The 128-bit key lives in four 32-bit registers on the APB port at byte
// addresses 0, 4, 8 and 12; write them only while no block is in flight.
// The datapath is a pipeline of 66 register stages: one input whitening stage,
// one stage per half cycle of the 32 cipher cycles, and one output whitening
// stage that drives blk_out. Blocks pass through the stages in order, and a new
// block can be taken in every cycle while no stall on blk_out backs up the pipe.
// Each stage holds its contents while the stage after it is full and not
// moving, so a stall on blk_out backs up stage by stage; empty stages keep
// filling, and blocks are accepted until the whole pipe is full.
// Synchronous reset empties the pipeline and clears all key registers to zero.
`default_nettype none

module xxtea_block_cipher_with_whitening_unit
  import xxt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Block channels.
  xxt_in_if.sink           blk_in,
  xxt_out_if.source        blk_out
);

  // Key registers.
  logic [31:0] key [4];
  logic [1:0]  reg_sel;

  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= '0;
      key[1] <= '0;
      key[2] <= '0;
      key[3] <= '0;
    end else if (psel && penable && pwrite) begin
      key[reg_sel] <= pwdata;
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx_t'(reg_sel))
      REG_KEY0: prdata = key[0];
      REG_KEY1: prdata = key[1];
      REG_KEY2: prdata = key[2];
      REG_KEY3: prdata = key[3];
      default:  prdata = '0;
    endcase
  end

  // Whitening words.
  logic [31:0] white_low;
  logic [31:0] white_high;

  assign white_low  = key[0] ^ key[2];
  assign white_high = key[1] ^ key[3];

  // Pipeline stage registers.
  logic        stg_valid [NUM_STAGES];
  logic        stg_ready [NUM_STAGES];
  cmd_t        stg_cmd   [NUM_STAGES];
  logic [31:0] stg_low   [NUM_STAGES];
  logic [31:0] stg_high  [NUM_STAGES];

  // A stage can load when it is empty or its contents move on.
  generate
    for (genvar s = 0; s < NUM_STAGES - 1; s++) begin : g_ready
      assign stg_ready[s] = !stg_valid[s] || stg_ready[s + 1];
    end
  endgenerate
  assign stg_ready[NUM_STAGES - 1] = !stg_valid[NUM_STAGES - 1] || blk_out.ready;

  assign blk_in.ready = stg_ready[0];

  // Input stage: encryption whitens before the cipher cycles.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else if (stg_ready[0]) begin
      stg_valid[0] <= blk_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready[0]) begin
      stg_cmd[0] <= blk_in.command;
      if (blk_in.command == CMD_ENCRYPT) begin
        stg_low[0]  <= blk_in.block_low ^ white_low;
        stg_high[0] <= blk_in.block_high ^ white_high;
      end else begin
        stg_low[0]  <= blk_in.block_low;
        stg_high[0] <= blk_in.block_high;
      end
    end
  end

  // One stage per half cycle; encryption and decryption share the stage.
  generate
    for (genvar h = 0; h < NUM_HALF; h++) begin : g_half
      localparam int          CYC     = h / 2;
      localparam bit          SECOND  = (h % 2) == 1;
      localparam logic [63:0] ENC_P   = 64'(DELTA) * 64'(CYC + 1);
      localparam logic [63:0] DEC_P   = 64'(DELTA) * 64'(NUM_CYCLES - CYC);
      localparam logic [31:0] ENC_SUM = ENC_P[31:0];
      localparam logic [31:0] DEC_SUM = DEC_P[31:0];
      localparam logic [1:0]  ENC_E   = ENC_SUM[3:2];
      localparam logic [1:0]  DEC_E   = DEC_SUM[3:2];
      // Encryption updates the low word first, decryption the high word.
      localparam logic [1:0]  ENC_K   = ENC_E ^ (SECOND ? 2'd1 : 2'd0);
      localparam logic [1:0]  DEC_K   = DEC_E ^ (SECOND ? 2'd0 : 2'd1);

      logic        src_is_high;
      logic [31:0] src_word;
      logic [31:0] tgt_word;
      logic [31:0] mix_val;
      logic [31:0] new_word;

      // The updated word is the low word for encryption first halves and
      // decryption second halves.
      always_comb begin
        if (stg_cmd[h] == CMD_ENCRYPT) begin
          src_is_high = !SECOND;
          mix_val     = mix(SECOND ? stg_low[h] : stg_high[h], ENC_SUM, key[ENC_K]);
        end else begin
          src_is_high = SECOND;
          mix_val     = mix(SECOND ? stg_high[h] : stg_low[h], DEC_SUM, key[DEC_K]);
        end
        src_word = src_is_high ? stg_high[h] : stg_low[h];
        tgt_word = src_is_high ? stg_low[h] : stg_high[h];
        if (stg_cmd[h] == CMD_ENCRYPT) begin
          new_word = tgt_word + mix_val;
        end else begin
          new_word = tgt_word - mix_val;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          stg_valid[h + 1] <= 1'b0;
        end else if (stg_ready[h + 1]) begin
          stg_valid[h + 1] <= stg_valid[h];
        end
      end

      always_ff @(posedge clk) begin
        if (stg_ready[h + 1]) begin
          stg_cmd[h + 1] <= stg_cmd[h];
          if (src_is_high) begin
            stg_low[h + 1]  <= new_word;
            stg_high[h + 1] <= src_word;
          end else begin
            stg_low[h + 1]  <= src_word;
            stg_high[h + 1] <= new_word;
          end
        end
      end
    end
  endgenerate

  // Output stage: decryption removes the whitening after the cipher cycles.
  localparam int LAST = NUM_STAGES - 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[LAST] <= 1'b0;
    end else if (stg_ready[LAST]) begin
      stg_valid[LAST] <= stg_valid[LAST - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready[LAST]) begin
      stg_cmd[LAST] <= stg_cmd[LAST - 1];
      if (stg_cmd[LAST - 1] == CMD_DECRYPT) begin
        stg_low[LAST]  <= stg_low[LAST - 1] ^ white_low;
        stg_high[LAST] <= stg_high[LAST - 1] ^ white_high;
      end else begin
        stg_low[LAST]  <= stg_low[LAST - 1];
        stg_high[LAST] <= stg_high[LAST - 1];
      end
    end
  end

  assign blk_out.valid       = stg_valid[LAST];
  assign blk_out.result_low  = stg_low[LAST];
  assign blk_out.result_high = stg_high[LAST];

endmodule

`default_nettype wire
